// ===== rtl/gcdb_pkg.sv =====
package gcdb_pkg;

    // how the back end treats a queued transaction
    typedef enum logic [1:0] {
        KIND_GCD    = 2'd0,
        KIND_TAKE_A = 2'd1,
        KIND_TAKE_B = 2'd2
    } kind_t;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ===== rtl/gcdb_front.sv =====
module gcdb_front #(
    parameter int WORD_BITS = 64
) (
    input  logic                   operand_valid,
    output logic                   operand_stall,
    input  logic signed [63:0]     operand_a,
    input  logic signed [63:0]     operand_b,
    input  gcdb_pkg::queue_status_t status,
    output logic                   push,
    output logic [2*WORD_BITS+$bits(gcdb_pkg::kind_t)-1:0] entry
);
    import gcdb_pkg::*;

    logic [WORD_BITS-1:0] raw_a;
    logic [WORD_BITS-1:0] raw_b;
    logic [WORD_BITS-1:0] mag_a;
    logic [WORD_BITS-1:0] mag_b;
    kind_t                kind;

    assign raw_a = operand_a[WORD_BITS-1:0];
    assign raw_b = operand_b[WORD_BITS-1:0];

    // most negative value maps onto itself, read unsigned
    assign mag_a = raw_a[WORD_BITS-1] ? (~raw_a + 1'b1) : raw_a;
    assign mag_b = raw_b[WORD_BITS-1] ? (~raw_b + 1'b1) : raw_b;

    always_comb
    begin
        if (mag_a == '0)
        begin
            kind = KIND_TAKE_B;
        end
        else if (mag_b == '0)
        begin
            kind = KIND_TAKE_A;
        end
        else
        begin
            kind = KIND_GCD;
        end
    end

    assign operand_stall = status.full;
    assign push          = operand_valid && !status.full;
    assign entry         = {kind, mag_a, mag_b};

endmodule

// ===== rtl/gcdb_queue.sv =====
module gcdb_queue #(
    parameter int ENTRY_BITS = 130
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  logic [ENTRY_BITS-1:0]   push_data,
    input  logic                    pop,
    output logic [ENTRY_BITS-1:0]   head,
    output gcdb_pkg::queue_status_t status
);
    import gcdb_pkg::*;

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    logic [ENTRY_BITS-1:0] slot_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [CNT_BITS-1:0]   count_reg;
    logic [PTR_BITS-1:0]   wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_next;
    logic [CNT_BITS-1:0]   count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                    : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                    : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head         = slot_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_BITS'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

// ===== rtl/gcdb_core.sv =====
module gcdb_core #(
    parameter int WORD_BITS = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [2*WORD_BITS+$bits(gcdb_pkg::kind_t)-1:0] head,
    input  gcdb_pkg::queue_status_t status,
    output logic                   pop,
    output logic                   divisor_valid,
    input  logic                   divisor_stall,
    output logic [WORD_BITS-1:0]   result
);
    import gcdb_pkg::*;

    localparam int SH_BITS = $clog2(WORD_BITS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHARE,
        ST_REDUCE,
        ST_FINISH
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [WORD_BITS-1:0] a_reg;
    logic [WORD_BITS-1:0] a_next;
    logic [WORD_BITS-1:0] b_reg;
    logic [WORD_BITS-1:0] b_next;
    logic [SH_BITS-1:0]   shared_reg;
    logic [SH_BITS-1:0]   shared_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [WORD_BITS-1:0] result_reg;
    logic [WORD_BITS-1:0] result_next;

    kind_t                head_kind;
    logic [WORD_BITS-1:0] head_a;
    logic [WORD_BITS-1:0] head_b;
    logic                 out_free;
    logic                 a_lt_b;
    logic [WORD_BITS-1:0] diff;

    assign head_kind = kind_t'(head[2*WORD_BITS +: $bits(kind_t)]);
    assign head_a    = head[WORD_BITS +: WORD_BITS];
    assign head_b    = head[0 +: WORD_BITS];
    assign out_free  = !out_valid_reg || !divisor_stall;
    assign a_lt_b    = (a_reg < b_reg);
    assign diff      = a_lt_b ? (b_reg - a_reg) : (a_reg - b_reg);

    always_comb
    begin
        state_next     = state_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        shared_next    = shared_reg;
        out_valid_next = out_valid_reg && divisor_stall;
        result_next    = result_reg;
        pop            = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!status.empty)
                begin
                    pop         = 1'b1;
                    a_next      = head_a;
                    b_next      = head_b;
                    shared_next = '0;
                    case (head_kind)
                        KIND_GCD:    state_next = ST_SHARE;
                        KIND_TAKE_A: state_next = ST_FINISH;
                        KIND_TAKE_B:
                        begin
                            a_next     = head_b;
                            state_next = ST_FINISH;
                        end
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SHARE:
            begin
                // common power of two
                if (!(a_reg[0] || b_reg[0]))
                begin
                    a_next      = a_reg >> 1;
                    b_next      = b_reg >> 1;
                    shared_next = SH_BITS'(shared_reg + 1'b1);
                end
                else
                begin
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (!a_reg[0] || !b_reg[0])
                begin
                    if (!a_reg[0])
                    begin
                        a_next = a_reg >> 1;
                    end
                    if (!b_reg[0])
                    begin
                        b_next = b_reg >> 1;
                    end
                end
                else if (a_reg == b_reg)
                begin
                    state_next = ST_FINISH;
                end
                else if (a_lt_b)
                begin
                    // difference of two odds is even
                    b_next = diff >> 1;
                end
                else
                begin
                    a_next = diff >> 1;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    result_next    = a_reg << shared_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            a_reg         <= '0;
            b_reg         <= '0;
            shared_reg    <= '0;
            out_valid_reg <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            shared_reg    <= shared_next;
            out_valid_reg <= out_valid_next;
            result_reg    <= result_next;
        end
    end

    assign divisor_valid = out_valid_reg;
    assign result        = result_reg;

endmodule

// ===== rtl/binary_gcd_signed64.sv =====
// channel   | handshake                      | payload
// ----------+--------------------------------+-----------------------------------
// operand   | operand_valid / operand_stall  | operand_a, operand_b (signed)
// divisor   | divisor_valid / divisor_stall  | divisor (unsigned, up to 2^(W-1))
//
// a transaction with a zero operand skips the core loop: the core goes from idle
// straight to its finish state; otherwise the core loop does one halving
// or one subtract-and-halve per cycle on a single shared subtractor
// reset clears the queue, the core state and divisor_valid at once
// operand_stall rises only when the two-entry queue is full, so transactions
// keep coming in while the core works and while a result waits on divisor_stall
module binary_gcd_signed64 #(
    parameter int WORD_BITS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               operand_valid,
    output logic               operand_stall,
    input  logic signed [63:0] operand_a,
    input  logic signed [63:0] operand_b,
    output logic               divisor_valid,
    input  logic               divisor_stall,
    output logic [63:0]        divisor
);
    import gcdb_pkg::*;

    // queued transaction: kind, |a|, |b|
    localparam int ENTRY_BITS = 2*WORD_BITS + $bits(kind_t);

    queue_status_t         status;
    logic                  push;
    logic                  pop;
    logic [ENTRY_BITS-1:0] entry;
    logic [ENTRY_BITS-1:0] head;
    logic [WORD_BITS-1:0]  result;

    // front: magnitudes and zero classification, straight into the queue
    gcdb_front #(
        .WORD_BITS(WORD_BITS)
    ) u_front (
        .operand_valid(operand_valid),
        .operand_stall(operand_stall),
        .operand_a    (operand_a),
        .operand_b    (operand_b),
        .status       (status),
        .push         (push),
        .entry        (entry)
    );

    // short queue decoupling acceptance from the iterative core
    gcdb_queue #(
        .ENTRY_BITS(ENTRY_BITS)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(entry),
        .pop      (pop),
        .head     (head),
        .status   (status)
    );

    // back: binary gcd sequencer with its own output register
    gcdb_core #(
        .WORD_BITS(WORD_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .status       (status),
        .pop          (pop),
        .divisor_valid(divisor_valid),
        .divisor_stall(divisor_stall),
        .result       (result)
    );

    // zero-extend to the port width
    assign divisor = 64'(result);

endmodule

// ===== rtl/gcdb_checker.sv =====
module gcdb_checker #(
    parameter int WORD_BITS = 64
) (
    input logic               clk,
    input logic               rst_n,
    input logic               operand_valid,
    input logic               operand_stall,
    input logic signed [63:0] operand_a,
    input logic signed [63:0] operand_b,
    input logic               divisor_valid,
    input logic               divisor_stall,
    input logic [63:0]        divisor
);
    import gcdb_pkg::*;

    // queue holds QUEUE_DEPTH transactions, core and output register one each at most
    localparam int MAX_OPEN = QUEUE_DEPTH + 2;

    logic [3:0] open_reg;
    logic       in_take;
    logic       out_take;

    assign in_take  = operand_valid && !operand_stall;
    assign out_take = divisor_valid && !divisor_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
        end
        else if (in_take && !out_take)
        begin
            open_reg <= open_reg + 1'b1;
        end
        else if (out_take && !in_take)
        begin
            open_reg <= open_reg - 1'b1;
        end
    end

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        divisor_valid && divisor_stall |=> divisor_valid && $stable(divisor))
        else $error("divisor changed while stalled");

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        divisor_valid |-> open_reg != '0)
        else $error("divisor transaction without a pending operand transaction");

    a_bounded_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg <= 4'(MAX_OPEN))
        else $error("more transactions in flight than the design can hold");

    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        divisor_valid |-> divisor <= (64'd1 << (WORD_BITS - 1)))
        else $error("divisor above the largest possible magnitude");

endmodule

bind binary_gcd_signed64 gcdb_checker #(.WORD_BITS(WORD_BITS)) u_gcdb_checker (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    import gcdb_pkg::*;

    // clock and run limits
    localparam int HALF_PERIOD  = 10;
    localparam int CYCLE_LIMIT  = 1000000;
    // drain wait covers the worst core loop, plus room for a stalled result
    localparam int DRAIN_CYCLES = 200;
    localparam int RANDOM_PAIRS = 1125;
    localparam int MAX_PRINTED  = 40;

    localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MOST_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    // shapes of random operand pairs
    typedef enum int {
        SHAPE_RANDOM,
        SHAPE_COMMON_FACTOR,
        SHAPE_POW2,
        SHAPE_SMALL,
        SHAPE_SPECIAL,
        SHAPE_MULTIPLE
    } pair_shape_t;

    // receiver stall modes
    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_SOLID
    } stall_mode_t;

    // one outstanding transaction and the divisor it must produce
    typedef struct {
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] divisor;
    } gcd_case_t;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               operand_valid = 1'b0;
    logic               operand_stall;
    logic signed [63:0] operand_a     = '0;
    logic signed [63:0] operand_b     = '0;
    logic               divisor_valid;
    logic               divisor_stall = 1'b0;
    logic [63:0]        divisor;

    gcd_case_t   pending_divisors[$];
    int          error_count    = 0;
    int          checked_count  = 0;
    int          sent_count     = 0;
    int          zero_count     = 0;
    int          most_neg_count = 0;
    int          cycle_count    = 0;
    int          burst_left     = 1;
    int          stall_left     = 0;
    stall_mode_t stall_mode     = STALL_NONE;

    binary_gcd_signed64 dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .operand_valid (operand_valid),
        .operand_stall (operand_stall),
        .operand_a     (operand_a),
        .operand_b     (operand_b),
        .divisor_valid (divisor_valid),
        .divisor_stall (divisor_stall),
        .divisor       (divisor)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // gcd predictor: magnitudes as unsigned words, then stein's method
    // ------------------------------------------------------------------

    function automatic logic [63:0] expected_gcd(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] x;
        logic [63:0] y;
        int          twos;
        // two's complement magnitude, the most negative value maps to 2^63
        x = a[63] ? (~a + 64'd1) : a;
        y = b[63] ? (~b + 64'd1) : b;
        twos = 0;
        if (x == 64'd0)
            return y;
        if (y == 64'd0)
            return x;
        // pull out the common power of two
        while (!x[0] && !y[0])
        begin
            x = x >> 1;
            y = y >> 1;
            twos++;
        end
        while (!x[0])
            x = x >> 1;
        while (!y[0])
            y = y >> 1;
        // both odd: the difference is even, so halve at least once
        while (x != y)
        begin
            if (x > y)
            begin
                x = (x - y) >> 1;
                while (!x[0])
                    x = x >> 1;
            end
            else
            begin
                y = (y - x) >> 1;
                while (!y[0])
                    y = y >> 1;
            end
        end
        return x << twos;
    endfunction

    // ------------------------------------------------------------------
    // random value helpers
    // ------------------------------------------------------------------

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // random value with at most the given number of significant bits
    function automatic logic [63:0] rand_bits(input int width);
        return rand_word() >> (64 - width);
    endfunction

    function automatic logic [63:0] maybe_negate(input logic [63:0] x);
        return ($urandom_range(0, 1) == 1) ? (~x + 64'd1) : x;
    endfunction

    // values around the corners of the signed range
    function automatic logic [63:0] special_value();
        case ($urandom_range(0, 5))
            0: return 64'd0;
            1: return MOST_NEG;
            2: return 64'd1;
            3: return ALL_ONES;
            4: return MOST_POS;
            default: return 64'd1 << $urandom_range(0, 63);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // mismatch reporting, printing is capped but every mismatch counts
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [63:0] a,
                                   input logic [63:0] b, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("mismatch at cycle %0d: %s a=%0d b=%0d got %0d want %0d",
                     cycle_count, what, $signed(a), $signed(b), got, want);
    endtask

    // ------------------------------------------------------------------
    // sender: one transaction per call, bursts with random gaps between
    // valid stays high across a burst, payload held while stalled
    // ------------------------------------------------------------------

    task automatic send_pair(input logic [63:0] a, input logic [63:0] b);
        gcd_case_t entry;
        entry.a       = a;
        entry.b       = b;
        entry.divisor = expected_gcd(a, b);
        operand_valid <= 1'b1;
        operand_a     <= a;
        operand_b     <= b;
        do
            @(posedge clk);
        while (operand_stall);
        // accepted at this edge
        pending_divisors.push_back(entry);
        sent_count++;
        if (a == 64'd0 || b == 64'd0)
            zero_count++;
        if (a == MOST_NEG || b == MOST_NEG)
            most_neg_count++;
        burst_left--;
        if (burst_left <= 0)
        begin
            operand_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            // now and then a long burst with no idling at all
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // ------------------------------------------------------------------
    // receiver: stall pattern that switches between modes over time
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (!rst_n)
            divisor_stall <= 1'b0;
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                stall_left = (stall_mode == STALL_SOLID) ? $urandom_range(1, 15)
                                                         : $urandom_range(5, 60);
            end
            stall_left--;
            case (stall_mode)
                STALL_NONE:  divisor_stall <= 1'b0;
                STALL_LIGHT: divisor_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: divisor_stall <= ($urandom_range(0, 3) != 0);
                default:     divisor_stall <= 1'b1;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // checker: each accepted divisor against the oldest outstanding one
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : check_divisor
        gcd_case_t oldest;
        if (rst_n && divisor_valid && !divisor_stall)
        begin
            if (pending_divisors.size() == 0)
                report_mismatch("divisor with no transaction outstanding",
                                64'd0, 64'd0, divisor, 64'd0);
            else
            begin
                oldest = pending_divisors.pop_front();
                checked_count++;
                if (divisor !== oldest.divisor)
                    report_mismatch("divisor", oldest.a, oldest.b, divisor, oldest.divisor);
            end
        end
    end

    // cycle limit guards against a hung handshake
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("run stopped at the cycle limit with %0d divisors outstanding",
                     pending_divisors.size());
            $display("[binary_gcd_signed64] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // directed tests
    // ------------------------------------------------------------------

    // a zero operand passes the other magnitude through
    task automatic test_zero_operands();
        send_pair(64'd0, 64'd0);
        send_pair(64'd0, 64'd5);
        send_pair(-64'd7, 64'd0);
        send_pair(64'd0, MOST_NEG);
        send_pair(MOST_NEG, 64'd0);
        send_pair(64'd0, MOST_POS);
        send_pair(MOST_NEG + 64'd1, 64'd0);
    endtask

    // most negative value taken as 2^63
    task automatic test_most_negative();
        send_pair(MOST_NEG, MOST_NEG);
        send_pair(MOST_NEG, 64'd1);
        send_pair(MOST_NEG, ALL_ONES);
        send_pair(MOST_NEG, MOST_POS);
        send_pair(64'd1 << 40, MOST_NEG);
        send_pair(MOST_NEG, 64'hC000_0000_0000_0000);
    endtask

    // largest magnitudes, equal values and long subtract chains
    task automatic test_word_extremes();
        send_pair(MOST_POS, MOST_POS);
        send_pair(MOST_POS, ~MOST_POS + 64'd1);
        send_pair(ALL_ONES, ALL_ONES);
        send_pair(64'd1, MOST_POS);
        send_pair(MOST_POS, MOST_POS - 64'd1);
        // consecutive fibonacci numbers
        send_pair(64'd4660046610375530309, 64'd7540113804746346429);
        // two mersenne primes
        send_pair((64'd1 << 61) - 64'd1, -((64'd1 << 31) - 64'd1));
    endtask

    // common and uneven powers of two
    task automatic test_shared_powers_of_two();
        send_pair(64'd3 << 40, 64'd9 << 20);
        send_pair(~(64'd5 << 50) + 64'd1, 64'd15 << 3);
        send_pair(64'd48, -64'd18);
        send_pair(64'd1 << 62, 64'd1 << 61);
        send_pair(-64'd1024, -64'd96);
    endtask

    // ------------------------------------------------------------------
    // random pairs in several shapes
    // ------------------------------------------------------------------

    task automatic test_random_pairs(input int count);
        pair_shape_t shape;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] g;
        int          pick;
        repeat (count)
        begin
            pick  = $urandom_range(0, 99);
            shape = (pick < 30) ? SHAPE_RANDOM :
                    (pick < 55) ? SHAPE_COMMON_FACTOR :
                    (pick < 65) ? SHAPE_POW2 :
                    (pick < 75) ? SHAPE_SMALL :
                    (pick < 87) ? SHAPE_SPECIAL : SHAPE_MULTIPLE;
            case (shape)
                SHAPE_RANDOM:
                begin
                    a = rand_word();
                    b = rand_word();
                end
                SHAPE_COMMON_FACTOR:
                begin
                    // shared factor: a random value shifted by a random power of two
                    g = rand_bits($urandom_range(1, 40)) << $urandom_range(0, 12);
                    a = maybe_negate(g * rand_bits($urandom_range(1, 24)));
                    b = maybe_negate(g * rand_bits($urandom_range(1, 24)));
                end
                SHAPE_POW2:
                begin
                    a = maybe_negate(rand_bits($urandom_range(1, 32)) << $urandom_range(0, 31));
                    b = maybe_negate(rand_bits($urandom_range(1, 32)) << $urandom_range(0, 31));
                end
                SHAPE_SMALL:
                begin
                    a = maybe_negate(64'($urandom_range(0, 1000)));
                    b = maybe_negate(64'($urandom_range(0, 1000)));
                end
                SHAPE_SPECIAL:
                begin
                    a = special_value();
                    b = ($urandom_range(0, 1) == 1) ? special_value() : rand_word();
                    if ($urandom_range(0, 1) == 1)
                    begin
                        g = a;
                        a = b;
                        b = g;
                    end
                end
                default:
                begin
                    // equal values or one a small multiple of the other
                    a = maybe_negate(rand_bits($urandom_range(1, 58)));
                    b = maybe_negate(a * $urandom_range(1, 31));
                end
            endcase
            send_pair(a, b);
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        burst_left = $urandom_range(1, 12);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_operands();
        test_most_negative();
        test_word_extremes();
        test_shared_powers_of_two();
        test_random_pairs(RANDOM_PAIRS);

        operand_valid <= 1'b0;
        // every outstanding transaction must come back, then watch for extras
        while (pending_divisors.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d operand pairs, %0d with a zero operand, %0d with the most negative value",
                 sent_count, zero_count, most_neg_count);
        $display("checked %0d divisors in %0d cycles, %0d mismatches",
                 checked_count, cycle_count, error_count);
        if (error_count == 0)
            $display("[binary_gcd_signed64] OK");
        else
            $display("[binary_gcd_signed64] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/gcdb_pkg.sv
rtl/gcdb_front.sv
rtl/gcdb_queue.sv
rtl/gcdb_core.sv
rtl/binary_gcd_signed64.sv
rtl/gcdb_checker.sv
bench/tb_top.sv
